/* hw/rtl/u8d_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared widths, lead-byte masks, result record and lead classification for
// the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 21;
  localparam int unsigned CountW = 3;
  localparam int unsigned LeftW  = 2;
  localparam int unsigned ContW  = 6;

  // Lead-byte class masks and payload masks
  localparam logic [ByteW-1:0] Lead4Mask = 8'b1111_0000;
  localparam logic [ByteW-1:0] Lead3Mask = 8'b1110_0000;
  localparam logic [ByteW-1:0] Lead2Mask = 8'b1100_0000;
  localparam logic [ByteW-1:0] AsciiMax  = 8'h7f;
  localparam logic [ByteW-1:0] Seed4Mask = 8'b0000_0111;
  localparam logic [ByteW-1:0] Seed3Mask = 8'b0000_1111;
  localparam logic [ByteW-1:0] Seed2Mask = 8'b0001_1111;
  localparam logic [ByteW-1:0] ContMask  = 8'b0011_1111;

  localparam logic [CountW-1:0] Len1 = 3'd1;
  localparam logic [CountW-1:0] Len2 = 3'd2;
  localparam logic [CountW-1:0] Len3 = 3'd3;
  localparam logic [CountW-1:0] Len4 = 3'd4;

  typedef enum logic [2:0] {
    LEAD_END,
    LEAD_ASCII,
    LEAD_STRAY,
    LEAD_SEQ2,
    LEAD_SEQ3,
    LEAD_SEQ4
  } lead_e;

  typedef struct packed {
    logic [CodeW-1:0]  code_point;
    logic [CountW-1:0] byte_count;
    logic              stray_byte;
    logic              string_end;
  } u8d_res_t;

  function automatic lead_e lead_class(logic [ByteW-1:0] b);
    lead_e cls;
    priority if (b == '0) begin
      cls = LEAD_END;
    end else if (b <= AsciiMax) begin
      cls = LEAD_ASCII;
    end else if ((b & Lead4Mask) == Lead4Mask) begin
      cls = LEAD_SEQ4;
    end else if ((b & Lead3Mask) == Lead3Mask) begin
      cls = LEAD_SEQ3;
    end else if ((b & Lead2Mask) == Lead2Mask) begin
      cls = LEAD_SEQ2;
    end else begin
      cls = LEAD_STRAY;
    end
    return cls;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/u8d_in_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_in_stage
// Input register: holds one byte until the decode step takes it.
// ----------------------------------------------------------------------------
module u8d_in_stage
  import u8d_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [ByteW-1:0] data_i,
  input  wire logic             advance_i,
  output logic                  vld_o,
  output logic [ByteW-1:0]      data_o
);

  logic             vld_q, vld_d;
  logic [ByteW-1:0] data_q;
  logic             take;

  assign ready_o = !vld_q || advance_i;
  assign take    = valid_i && ready_o;
  assign vld_d   = take || (vld_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= data_i;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule
`default_nettype wire

/* hw/rtl/u8d_decode.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_decode
// Sequence state and one-byte decode step: lead classification, accumulator
// shift and result formation.
// ----------------------------------------------------------------------------
module u8d_decode
  import u8d_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [ByteW-1:0] data_i,
  input  wire logic             step_i,
  output logic                  has_res_o,
  output u8d_res_t              res_o
);

  logic [LeftW-1:0]  left_q, left_d;
  logic [CodeW-1:0]  acc_q, acc_d;
  logic [CountW-1:0] len_q, len_d;
  logic [CodeW-1:0]  acc_cont;

  // Shift the low six bits of a continuation byte into the accumulator
  assign acc_cont = {acc_q[CodeW-ContW-1:0], data_i[ContW-1:0]};

  always_comb begin
    left_d    = left_q;
    acc_d     = acc_q;
    len_d     = len_q;
    has_res_o = 1'b0;
    res_o     = '0;
    if (left_q != '0) begin
      if (left_q == LeftW'(1)) begin
        has_res_o        = 1'b1;
        res_o.code_point = acc_cont;
        res_o.byte_count = len_q;
        left_d           = '0;
        acc_d            = '0;
        len_d            = '0;
      end else begin
        left_d = left_q - LeftW'(1);
        acc_d  = acc_cont;
      end
    end else begin
      unique case (lead_class(data_i))
        LEAD_END: begin
          has_res_o        = 1'b1;
          res_o.string_end = 1'b1;
          acc_d            = '0;
          len_d            = '0;
        end
        LEAD_ASCII: begin
          has_res_o        = 1'b1;
          res_o.code_point = CodeW'(data_i);
          res_o.byte_count = Len1;
        end
        LEAD_STRAY: begin
          has_res_o        = 1'b1;
          res_o.byte_count = Len1;
          res_o.stray_byte = 1'b1;
          acc_d            = '0;
          len_d            = '0;
        end
        LEAD_SEQ2: begin
          left_d = LeftW'(1);
          acc_d  = CodeW'(data_i & Seed2Mask);
          len_d  = Len2;
        end
        LEAD_SEQ3: begin
          left_d = LeftW'(2);
          acc_d  = CodeW'(data_i & Seed3Mask);
          len_d  = Len3;
        end
        LEAD_SEQ4: begin
          left_d = LeftW'(3);
          acc_d  = CodeW'(data_i & Seed4Mask);
          len_d  = Len4;
        end
        default: begin
          has_res_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      acc_q  <= '0;
      len_q  <= '0;
    end else if (step_i) begin
      left_q <= left_d;
      acc_q  <= acc_d;
      len_q  <= len_d;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/u8d_out_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_out_stage
// Result register: holds a decoded result until the receiver takes it.
// ----------------------------------------------------------------------------
module u8d_out_stage
  import u8d_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     load_i,
  input  wire u8d_res_t res_i,
  input  wire logic     ready_i,
  output logic          free_o,
  output logic          valid_o,
  output u8d_res_t      res_o
);

  logic     vld_q, vld_d;
  u8d_res_t res_q;

  assign free_o = !vld_q || ready_i;
  assign vld_d  = load_i || (vld_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire

/* hw/rtl/utf8_stream_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// UTF-8 byte stream to code point decoder, no validation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (valid_i/ready_o): one raw byte per transfer on
//   data_byte_i. Output channel (valid_o/ready_i): one result per transfer,
//   with code_point_o, byte_count_o, stray_byte_o and string_end_o.
//   Lead bytes of a multi-byte sequence and all but the last continuation
//   byte produce no result; the last byte of a sequence, an ASCII byte, a
//   NUL lead byte (end of string) and a stray continuation byte each give one.
// Timing:
//   A byte sits in the input register, the decode step runs between that
//   register and the result register, and the result is registered there
//   before it shows on valid_o. One byte is taken every cycle unless a
//   result must wait for room in the single result register, the only limit.
// Reset:
//   rst_ni clears both valid flags and the sequence state (no sequence open).
// Stall:
//   While the receiver holds ready_i low with a result pending, a byte that
//   makes a result waits in the input register and ready_o drops; a byte that
//   makes no result still advances.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
  import u8d_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire logic [ByteW-1:0]  data_byte_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic [CodeW-1:0]       code_point_o,
  output logic [CountW-1:0]      byte_count_o,
  output logic                   stray_byte_o,
  output logic                   string_end_o
);

  logic             in_vld;
  logic [ByteW-1:0] in_data;
  logic             has_res;
  logic             out_free;
  logic             advance;
  u8d_res_t         dec_res;
  u8d_res_t         out_res;

  // Advance the held byte when its result (if any) has room downstream
  assign advance = in_vld && (!has_res || out_free);

  u8d_in_stage u_in (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_i),
    .ready_o  (ready_o),
    .data_i   (data_byte_i),
    .advance_i(advance),
    .vld_o    (in_vld),
    .data_o   (in_data)
  );

  u8d_decode u_dec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .data_i   (in_data),
    .step_i   (advance),
    .has_res_o(has_res),
    .res_o    (dec_res)
  );

  u8d_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance && has_res),
    .res_i  (dec_res),
    .ready_i(ready_i),
    .free_o (out_free),
    .valid_o(valid_o),
    .res_o  (out_res)
  );

  assign code_point_o = out_res.code_point;
  assign byte_count_o = out_res.byte_count;
  assign stray_byte_o = out_res.stray_byte;
  assign string_end_o = out_res.string_end;

endmodule
`default_nettype wire

/* hw/rtl/u8d_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks on the decoder results, bound to the top level.
// ----------------------------------------------------------------------------
module u8d_checker
  import u8d_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              valid_o,
  input wire logic              ready_i,
  input wire logic [CodeW-1:0]  code_point_o,
  input wire logic [CountW-1:0] byte_count_o,
  input wire logic              stray_byte_o,
  input wire logic              string_end_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(code_point_o) && $stable(byte_count_o))
    else $error("result changed while stalled");

  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && string_end_o |->
      code_point_o == '0 && byte_count_o == '0 && !stray_byte_o)
    else $error("end marker carries payload");

  a_stray_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stray_byte_o |->
      code_point_o == '0 && byte_count_o == Len1 && !string_end_o)
    else $error("malformed stray-byte result");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !string_end_o |->
      byte_count_o == Len1 || byte_count_o == Len2 ||
      byte_count_o == Len3 || byte_count_o == Len4)
    else $error("byte count out of range");

  a_ascii_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && byte_count_o == Len1 && !stray_byte_o |->
      code_point_o != '0 && code_point_o <= CodeW'(AsciiMax))
    else $error("one-byte result outside ASCII");

endmodule

bind utf8_stream_decoder u8d_checker u_u8d_checker (.*);
`default_nettype wire

/* sim/utf8_decode_check.sv */
// ----------------------------------------------------------------------------
// utf8_decode_check
// Watches both channels of the UTF-8 stream decoder, predicts the result of
// every byte transfer and compares each result transfer with the oldest one.
// ----------------------------------------------------------------------------
module utf8_decode_check
  import u8d_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_valid_i,
  input  logic              byte_ready_i,
  input  logic [ByteW-1:0]  byte_i,
  input  logic              char_valid_i,
  input  logic              char_ready_i,
  input  logic [CodeW-1:0]  code_point_i,
  input  logic [CountW-1:0] byte_count_i,
  input  logic              stray_byte_i,
  input  logic              string_end_i,
  output int                fail_count_o,
  output int                chars_waiting_o,
  output int                chars_checked_o
);

  // Decoder state as the predictor sees it
  logic [LeftW-1:0]  cont_left;
  logic [CodeW-1:0]  code_acc;
  logic [CountW-1:0] seq_len;

  u8d_res_t expected_chars[$];
  u8d_res_t next_char;
  u8d_res_t oldest_char;
  int       fails;
  int       checked;

  function automatic void clear_sequence();
    cont_left = '0;
    code_acc  = '0;
    seq_len   = '0;
  endfunction

  // Advance the predicted state by one byte; return 1 when it makes a result.
  function automatic bit decode_byte(input logic [ByteW-1:0] b, output u8d_res_t res);
    lead_e cls;
    res = '0;
    if (cont_left != '0) begin
      code_acc  = {code_acc[CodeW-ContW-1:0], b[ContW-1:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left != '0) return 1'b0;
      res.code_point = code_acc;
      res.byte_count = seq_len;
      clear_sequence();
      return 1'b1;
    end
    if (b == 8'h00)      cls = LEAD_END;
    else if (b <= 8'h7f) cls = LEAD_ASCII;
    else if (b >= 8'hf0) cls = LEAD_SEQ4;
    else if (b >= 8'he0) cls = LEAD_SEQ3;
    else if (b >= 8'hc0) cls = LEAD_SEQ2;
    else                 cls = LEAD_STRAY;
    case (cls)
      LEAD_END: begin
        clear_sequence();
        res.string_end = 1'b1;
        return 1'b1;
      end
      LEAD_ASCII: begin
        res.code_point = CodeW'(b);
        res.byte_count = Len1;
        return 1'b1;
      end
      LEAD_SEQ4: begin
        seq_len = Len4; code_acc = CodeW'(b[2:0]); cont_left = 2'd3;
      end
      LEAD_SEQ3: begin
        seq_len = Len3; code_acc = CodeW'(b[3:0]); cont_left = 2'd2;
      end
      LEAD_SEQ2: begin
        seq_len = Len2; code_acc = CodeW'(b[4:0]); cont_left = 2'd1;
      end
      default: begin
        clear_sequence();
        res.byte_count = Len1;
        res.stray_byte = 1'b1;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic int field_check(input string fname, input int expv, input int actv);
    if (expv == actv) return 0;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, expv, actv);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_sequence();
      expected_chars.delete();
      fails           = 0;
      checked         = 0;
      fail_count_o    <= 0;
      chars_waiting_o <= 0;
      chars_checked_o <= 0;
    end else begin
      // A result always comes after its byte's transfer, so retire before predicting.
      if (char_valid_i && char_ready_i) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: result with nothing expected, actual %0h/%0d/%0b/%0b", $time,
                   code_point_i, byte_count_i, stray_byte_i, string_end_i);
          fails++;
        end else begin
          oldest_char = expected_chars.pop_front();
          fails += field_check("code_point", int'(oldest_char.code_point),
                               int'(code_point_i));
          fails += field_check("byte_count", int'(oldest_char.byte_count),
                               int'(byte_count_i));
          fails += field_check("stray_byte", int'(oldest_char.stray_byte),
                               int'(stray_byte_i));
          fails += field_check("string_end", int'(oldest_char.string_end),
                               int'(string_end_i));
          checked++;
        end
      end
      if (byte_valid_i && byte_ready_i) begin
        if (decode_byte(byte_i, next_char)) expected_chars.push_back(next_char);
      end
      fail_count_o    <= fails;
      chars_waiting_o <= expected_chars.size();
      chars_checked_o <= checked;
    end
  end

endmodule

/* sim/utf8_stream_decoder_test.sv */
// ----------------------------------------------------------------------------
// utf8_stream_decoder_test
// Drives byte streams into the UTF-8 stream decoder under changing idle mixes
// and a long output stall; a side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_test;
  import u8d_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int RandomBytesPerMix = 125;
  localparam int LongStall = 64;

  logic              clk_i;
  logic              rst_ni       = 1'b0;
  logic              valid_i      = 1'b0;
  logic              ready_o;
  logic [ByteW-1:0]  data_byte_i  = '0;
  logic              valid_o;
  logic              ready_i      = 1'b0;
  logic [CodeW-1:0]  code_point_o;
  logic [CountW-1:0] byte_count_o;
  logic              stray_byte_o;
  logic              string_end_o;

  int fail_count;
  int chars_waiting;
  int chars_checked;
  int bytes_sent     = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_left      = 0;
  bit stall_request  = 1'b0;

  utf8_stream_decoder i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .ready_o      (ready_o),
    .data_byte_i  (data_byte_i),
    .valid_o      (valid_o),
    .ready_i      (ready_i),
    .code_point_o (code_point_o),
    .byte_count_o (byte_count_o),
    .stray_byte_o (stray_byte_o),
    .string_end_o (string_end_o)
  );

  utf8_decode_check i_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .byte_valid_i    (valid_i),
    .byte_ready_i    (ready_o),
    .byte_i          (data_byte_i),
    .char_valid_i    (valid_o),
    .char_ready_i    (ready_i),
    .code_point_i    (code_point_o),
    .byte_count_i    (byte_count_o),
    .stray_byte_i    (stray_byte_o),
    .string_end_i    (string_end_o),
    .fail_count_o    (fail_count),
    .chars_waiting_o (chars_waiting),
    .chars_checked_o (chars_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: give up if the run hangs anywhere.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("utf8_stream_decoder regression: fail");
    $finish;
  end

  // Receiver: random back-pressure, or a counted long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_request) begin
        stall_request = 1'b0;
        hold_left     = LongStall;
      end
      if (hold_left != 0) begin
        ready_i <= 1'b0;
        hold_left--;
      end else begin
        ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one byte after a random idle gap; hold valid and the byte steady
  // until the transfer. Valid stays up afterwards so back-to-back bytes
  // need no second assignment in the same step.
  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i     <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!ready_o);
    bytes_sent++;
  endtask

  task automatic send_bytes(input logic [ByteW-1:0] seq[$]);
    foreach (seq[k]) send_byte(seq[k]);
  endtask

  // Continuation byte with a correct 10xxxxxx marker and random payload.
  function automatic logic [ByteW-1:0] cont_byte();
    return {2'b10, 6'($urandom_range(63))};
  endfunction

  // Random stream: mostly well-formed characters with random content, mixed with
  // end markers, stray continuations, cut-short sequences and raw noise.
  task automatic send_random_stream(input int nbytes);
    int start;
    int pick;
    int len;
    start = bytes_sent;
    while (bytes_sent - start < nbytes) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        len = $urandom_range(1, 4);
        case (len)
          1:       send_byte(ByteW'($urandom_range(1, 127)));
          2:       send_byte({3'b110, 5'($urandom_range(31))});
          3:       send_byte({4'b1110, 4'($urandom_range(15))});
          default: send_byte({5'b11110, 3'($urandom_range(7))});
        endcase
        repeat (len - 1) send_byte(cont_byte());
      end else if (pick < 65) begin
        send_byte(8'h00);
      end else if (pick < 78) begin
        send_byte(cont_byte());
      end else if (pick < 90) begin
        // Lead byte followed by zero to two continuations; when too few, the next
        // bytes get swallowed as payload.
        send_byte(ByteW'($urandom_range(8'hc0, 8'hff)));
        repeat ($urandom_range(0, 2)) send_byte(cont_byte());
      end else begin
        send_byte(ByteW'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    // Hold reset, then release it at an edge.
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 19;
    recv_idle_pct = 59;

    // Directed: field extremes and every lead class.
    send_bytes('{8'h01, 8'h7f});                  // one-byte characters
    send_bytes('{8'h80});                         // stray continuation
    send_bytes('{8'hc0, 8'h80});                  // smallest two-byte payload
    send_bytes('{8'hdf, 8'hbf});                  // largest two-byte payload
    send_bytes('{8'he0, 8'h80, 8'h80});
    send_bytes('{8'hef, 8'hff, 8'hff});           // bad markers, low six bits only
    send_bytes('{8'hf0, 8'h00, 8'h80, 8'h80});    // NUL inside a sequence is payload
    send_bytes('{8'hf7, 8'hbf, 8'hbf, 8'hbf});    // largest four-byte code point
    send_bytes('{8'hff, 8'h3f, 8'h7f, 8'hc0});    // 0xF8..0xFF lead, bare markers
    send_bytes('{8'h00});                         // end of string
    send_random_stream(RandomBytesPerMix);

    // Flip the idle mix: slow sender, eager receiver.
    send_idle_pct = 59;
    recv_idle_pct = 19;
    send_random_stream(RandomBytesPerMix);

    // No idling at all, opened by a long output stall so the result
    // register and the input register fill and ready_o drops.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 1'b1;
    repeat (20) send_byte(ByteW'($urandom_range(1, 127)));
    send_random_stream(RandomBytesPerMix);
    valid_i <= 1'b0;

    // Drain: the waiting count is registered, so wait for an edge before polling.
    @(posedge clk_i);
    while (chars_waiting != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d bytes sent, %0d results checked", bytes_sent, chars_checked);
    $display("covered ASCII, 2/3/4-byte, stray, end and broken sequences over three",
             " idle mixes and a long output stall");
    if (fail_count == 0) begin
      $display("utf8_stream_decoder regression: pass");
    end else begin
      $display("utf8_stream_decoder regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/u8d_pkg.sv
hw/rtl/u8d_in_stage.sv
hw/rtl/u8d_decode.sv
hw/rtl/u8d_out_stage.sv
hw/rtl/utf8_stream_decoder.sv
hw/rtl/u8d_checker.sv
sim/utf8_decode_check.sv
sim/utf8_stream_decoder_test.sv
